// ===== design/wmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types, field widths and register codes of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W      = 32;  // pixel word
  localparam int DIM_W      = 11;  // frame width / height registers
  localparam int WSZ_W      = 3;   // window side register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [DIM_W-1:0] WINDOW_SIZE_RST  = 11'd3;

  // per-word control that travels down the pipe
  typedef struct packed {
    logic res;   // word produces a result
    logic last;  // result closes the frame
  } item_ctl_t;

  // reach below/right of the center: size-1-size/2
  function automatic logic [WSZ_W-1:0] win_reach(input logic [WSZ_W-1:0] wsz);
    return wsz - 3'd1 - (wsz >> 1);
  endfunction

endpackage

// ===== design/wmf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_if
// Channel interfaces: pixel input, filtered output, register writes.
// ----------------------------------------------------------------------------
interface wmf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [wmf_pkg::PIX_W-1:0] pixel_value;
  modport source (output valid, operation, pixel_value, input ready);
  modport sink   (input valid, operation, pixel_value, output ready);
endinterface

interface wmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::PIX_W-1:0] filtered_value;
  logic                      last_of_frame;
  modport source (output valid, filtered_value, last_of_frame, input ready);
  modport sink   (input valid, filtered_value, last_of_frame, output ready);
endinterface

interface wmf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wmf_pkg::CFG_IDX_W-1:0]  index;
  logic [wmf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/window_median_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_filter_top
// 2-D sliding-window median over a raster pixel stream with line store RAM.
// ----------------------------------------------------------------------------
// Throughput: one word per clock, sustained; stalls only when the two-entry
//   output buffer is full, the sink holds off and the last pipe stage holds
//   a result.
// Path: the word that completes a window passes the RAM read, window shift,
//   compare, rank and pick steps before its result leaves the pipe.
// Reset: synchronous, active low; registers return to 1024 x 1024, size 3,
//   frame position zero. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module window_median_filter_top #(
  parameter int MAX_WINDOW = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  wmf_in_if.sink    in_ch,
  wmf_out_if.source out_ch,
  wmf_cfg_if.sink   cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = wmf_pkg::PIX_W;

  // out-of-range register values: zero reads as 1, above bound as bound
  function automatic logic [wmf_pkg::DIM_W-1:0] clamp_dim(
    input logic [wmf_pkg::DIM_W-1:0] v, input int unsigned bound);
    if (v == '0) return 11'd1;
    if (32'(v) > bound) return 11'(bound);
    return v;
  endfunction

  // ---- configuration registers ----
  logic [wmf_pkg::DIM_W-1:0] frame_w_r, frame_h_r;
  logic [wmf_pkg::WSZ_W-1:0] win_sz_r;
  logic                      cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= clamp_dim(wmf_pkg::FRAME_WIDTH_RST, MAX_WIDTH);
      frame_h_r <= clamp_dim(wmf_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT);
      win_sz_r  <= 3'(clamp_dim(wmf_pkg::WINDOW_SIZE_RST, MAX_WINDOW));
    end else if (cfg_we) begin
      unique case (cfg_ch.index)
        wmf_pkg::REG_FRAME_WIDTH:
          frame_w_r <= clamp_dim(cfg_ch.data[wmf_pkg::DIM_W-1:0], MAX_WIDTH);
        wmf_pkg::REG_FRAME_HEIGHT:
          frame_h_r <= clamp_dim(cfg_ch.data[wmf_pkg::DIM_W-1:0], MAX_HEIGHT);
        wmf_pkg::REG_WINDOW_SIZE:
          win_sz_r <= 3'(clamp_dim(11'(cfg_ch.data[wmf_pkg::WSZ_W-1:0]),
                                   MAX_WINDOW));
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // any write to a mapped register restarts the frame
  logic cfg_restart;
  assign cfg_restart = cfg_we && ((cfg_ch.index == wmf_pkg::REG_FRAME_WIDTH) ||
                                  (cfg_ch.index == wmf_pkg::REG_FRAME_HEIGHT) ||
                                  (cfg_ch.index == wmf_pkg::REG_WINDOW_SIZE));

  // ---- pipe enable and accept ----
  // The whole pipe moves together; it holds only when the last stage
  // carries a result and the output buffer cannot take it this cycle.
  logic [1:0] cnt_r;
  logic       space, en, acc, m_res;

  assign space       = (cnt_r != 2'd2) || out_ch.ready;
  assign en          = !m_res || space;
  assign in_ch.ready = en;
  assign acc         = in_ch.valid && en;
  // operation is not decoded: the frame position alone marks drain words

  // ---- stage 0: raster position ----
  logic [CW-1:0]      s0_col, s0_oc;
  logic [RW-1:0]      s0_or;
  wmf_pkg::item_ctl_t s0_ctl;

  wmf_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .restart (cfg_restart),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .win_sz  (win_sz_r),
    .col_o   (s0_col),
    .oc_o    (s0_oc),
    .or_o    (s0_or),
    .ctl_o   (s0_ctl)
  );

  // ---- stage 1/2: line store read-modify-write, window shift ----
  logic [PW-1:0] win [MAX_WINDOW][MAX_WINDOW];

  wmf_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .acc    (acc),
    .rd_col (s0_col),
    .pixel  (in_ch.pixel_value),
    .win_o  (win)
  );

  // output position rides alongside the line store stage
  wmf_pkg::item_ctl_t s1_ctl_r, s2_ctl_r;
  logic [CW-1:0]      s1_oc_r, s2_oc_r;
  logic [RW-1:0]      s1_or_r, s2_or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= '{res: acc && s0_ctl.res, last: s0_ctl.last};
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_oc_r <= s0_oc;
      s1_or_r <= s0_or;
      s2_oc_r <= s1_oc_r;
      s2_or_r <= s1_or_r;
    end
  end

  // ---- stage 3/4: rank select ----
  logic          m_last;
  logic [PW-1:0] m_value;

  wmf_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl     (s2_ctl_r),
    .oc      (s2_oc_r),
    .orow    (s2_or_r),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .win_sz  (win_sz_r),
    .win     (win),
    .res_o   (m_res),
    .last_o  (m_last),
    .value_o (m_value)
  );

  // ---- two-entry output buffer ----
  // Lets the pipe keep accepting while one result waits on the sink.
  logic [PW-1:0] buf_val_r [2];
  logic          buf_last_r [2];
  logic          wptr_r, rptr_r;
  logic          push, pop;

  assign push = m_res && en;
  assign pop  = (cnt_r != 2'd0) && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_val_r[wptr_r]  <= m_value;
      buf_last_r[wptr_r] <= m_last;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.filtered_value = buf_val_r[rptr_r];
  assign out_ch.last_of_frame  = buf_last_r[rptr_r];

  // ---- checks ----
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("result pushed into a full output buffer");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> m_res && (cnt_r == 2'd2) && !out_ch.ready)
    else $error("pipe held without a blocked result");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_restart |=> !m_res || $past(s1_ctl_r.res || s2_ctl_r.res) ||
                    $past(m_res) || $past(acc))
    else $error("result appeared from an empty pipe after a register write");

endmodule

// ===== design/wmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_ctrl
// Raster position of the incoming word and of the pending output pixel.
// ----------------------------------------------------------------------------
module wmf_ctrl #(
  parameter int MAX_WINDOW = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        restart,
  input  logic [wmf_pkg::DIM_W-1:0]   frame_w,
  input  logic [wmf_pkg::DIM_W-1:0]   frame_h,
  input  logic [wmf_pkg::WSZ_W-1:0]   win_sz,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  oc_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] or_o,
  output wmf_pkg::item_ctl_t            ctl_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int LAG_W = $clog2(MAX_WINDOW * (MAX_WIDTH + 1) + 1);
  localparam int PW    = wmf_pkg::WSZ_W + wmf_pkg::DIM_W;

  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    oc_r, oc_nxt;
  logic [RW-1:0]    orow_r, orow_nxt;
  logic [LAG_W-1:0] n_r, n_nxt;

  logic [wmf_pkg::WSZ_W-1:0] d;
  logic [PW-1:0]             dw;
  logic [LAG_W-1:0]          lag;
  logic [CW-1:0]             wm1;
  logic [RW-1:0]             hm1;
  logic                      started, last;

  assign d       = wmf_pkg::win_reach(win_sz);
  assign dw      = PW'(d) * PW'(frame_w);
  assign lag     = LAG_W'(dw) + LAG_W'(d);
  assign wm1     = CW'(frame_w - 11'd1);
  assign hm1     = RW'(frame_h - 11'd1);
  assign started = (n_r >= lag);
  assign last    = started && (oc_r == wm1) && (orow_r == hm1);

  assign col_o = col_r;
  assign oc_o  = oc_r;
  assign or_o  = orow_r;
  assign ctl_o = '{res: started, last: last};

  always_comb begin
    col_nxt  = col_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    n_nxt    = n_r;
    priority if (restart) begin
      col_nxt  = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
      n_nxt    = '0;
    end else if (acc) begin
      col_nxt = (col_r == wm1) ? '0 : col_r + 1'b1;
      if (!started) begin
        n_nxt = n_r + 1'b1;
      end else if (last) begin
        col_nxt  = '0;
        oc_nxt   = '0;
        orow_nxt = '0;
        n_nxt    = '0;
      end else if (oc_r == wm1) begin
        oc_nxt   = '0;
        orow_nxt = orow_r + 1'b1;
      end else begin
        oc_nxt = oc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      oc_r   <= '0;
      orow_r <= '0;
      n_r    <= '0;
    end else begin
      col_r  <= col_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
      n_r    <= n_nxt;
    end
  end

endmodule

// ===== design/wmf_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_window
// Line store RAM (one column stack per address) and the window columns.
// ----------------------------------------------------------------------------
module wmf_window #(
  parameter int MAX_WINDOW = 5,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic [wmf_pkg::PIX_W-1:0]    pixel,
  output logic [wmf_pkg::PIX_W-1:0]    win_o [MAX_WINDOW][MAX_WINDOW]
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int PW   = wmf_pkg::PIX_W;
  localparam int LB_N = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int LB_W = PW * LB_N;

  logic            s1_valid_r;
  logic [PW-1:0]   s1_pix_r;
  logic [CW-1:0]   s1_col_r;
  logic            fwd_r;
  logic [LB_W-1:0] wvec_r;
  logic [PW-1:0]   win_r [MAX_WINDOW][MAX_WINDOW];

  logic [LB_W-1:0] rdata, colvec, wdata;
  logic [PW-1:0]   newcol [MAX_WINDOW];
  logic            we;

  assign we = en && s1_valid_r;

  wmf_ram #(.WIDTH(LB_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_col_r),
    .wdata (wdata),
    .re    (en),
    .raddr (rd_col),
    .rdata (rdata)
  );

  // same column written by the previous word: RAM read returned old data
  assign colvec = fwd_r ? wvec_r : rdata;

  always_comb begin
    newcol[0] = s1_pix_r;
    for (int m = 1; m < MAX_WINDOW; m++) begin
      newcol[m] = colvec[(m-1)*PW +: PW];
    end
    for (int m = 0; m < LB_N; m++) begin
      wdata[m*PW +: PW] = newcol[m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
      fwd_r      <= acc && s1_valid_r && (rd_col == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r <= pixel;
      s1_col_r <= rd_col;
    end
    if (we) begin
      wvec_r <= wdata;
      win_r[0] <= newcol;
      for (int j = 1; j < MAX_WINDOW; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
  end

  assign win_o = win_r;

endmodule

// ===== design/wmf_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_median
// Rank select over the masked window: compare matrix, rank count, pick.
// ----------------------------------------------------------------------------
module wmf_median #(
  parameter int MAX_WINDOW = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  wmf_pkg::item_ctl_t            ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  oc,
  input  logic [$clog2(MAX_HEIGHT)-1:0] orow,
  input  logic [wmf_pkg::DIM_W-1:0]     frame_w,
  input  logic [wmf_pkg::DIM_W-1:0]     frame_h,
  input  logic [wmf_pkg::WSZ_W-1:0]     win_sz,
  input  logic [wmf_pkg::PIX_W-1:0]     win [MAX_WINDOW][MAX_WINDOW],
  output logic                          res_o,
  output logic                          last_o,
  output logic [wmf_pkg::PIX_W-1:0]     value_o
);

  localparam int PW  = wmf_pkg::PIX_W;
  localparam int N   = MAX_WINDOW * MAX_WINDOW;
  localparam int NW  = $clog2(N + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CXW = ((CW > wmf_pkg::DIM_W) ? CW : wmf_pkg::DIM_W) + 1;
  localparam int RXW = ((RW > wmf_pkg::DIM_W) ? RW : wmf_pkg::DIM_W) + 1;

  wmf_pkg::item_ctl_t s3_ctl_r, s4_ctl_r;
  logic [N-1:0]  s3_lt_r [N];
  logic [PW-1:0] s3_val_r [N];
  logic [N-1:0]  s3_vm_r;
  logic [NW-1:0] s4_rank_r [N];
  logic [NW-1:0] s4_tgt_r;
  logic [PW-1:0] s4_val_r [N];
  logic [N-1:0]  s4_vm_r;

  logic [wmf_pkg::WSZ_W-1:0] d;
  logic [CXW-1:0] cd;
  logic [RXW-1:0] rd;
  logic [N-1:0]   vm;
  logic [PW:0]    key [N];
  logic [PW-1:0]  val [N];
  logic [N-1:0]   lt [N];
  logic [NW-1:0]  rank [N];
  logic [PW-1:0]  pick;

  assign d  = wmf_pkg::win_reach(win_sz);
  assign cd = CXW'(oc) + CXW'(d);
  assign rd = RXW'(orow) + RXW'(d);

  // column j is the stack of the word j places back, slot m is m rows up;
  // an invalid cell sorts above every real pixel
  always_comb begin
    int e;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      for (int m = 0; m < MAX_WINDOW; m++) begin
        e = j * MAX_WINDOW + m;
        vm[e] = (j < int'(win_sz)) && (m < int'(win_sz)) &&
                (CXW'(j) <= cd) && ((cd - CXW'(j)) < CXW'(frame_w)) &&
                (RXW'(m) <= rd) && ((rd - RXW'(m)) < RXW'(frame_h));
        val[e] = win[j][m];
        key[e] = vm[e] ? {1'b0, win[j][m]} : {1'b1, {PW{1'b0}}};
      end
    end
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < N; k++) begin
        lt[i][k] = (k != i) &&
                   ((key[k] < key[i]) || ((key[k] == key[i]) && (k < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = NW'($countones(s3_lt_r[i]));
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      if (s4_vm_r[i] && (s4_rank_r[i] == s4_tgt_r)) begin
        pick = pick | s4_val_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (en) begin
      s3_ctl_r <= ctl;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lt_r  <= lt;
      s3_val_r <= val;
      s3_vm_r  <= vm;
      s4_rank_r <= rank;
      s4_tgt_r  <= NW'($countones(s3_vm_r)) >> 1;
      s4_val_r  <= s3_val_r;
      s4_vm_r   <= s3_vm_r;
    end
  end

  assign res_o   = s4_ctl_r.res;
  assign last_o  = s4_ctl_r.last;
  assign value_o = pick;

endmodule

// ===== tb/window_median_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_filter_top_tb
// Self-checking bench for the sliding-window median filter. A directed table
// covers register clamping, one-pixel frames and odd/even window sides. It is
// followed by extreme frame shapes and random frames, some cut short, under
// random gaps on the pixel input and random stalls on the result output.
// Every result is checked against an in-bench median model or a typed answer.
// ----------------------------------------------------------------------------
module window_median_filter_top_tb;

  localparam int HIST_LEN   = 4 * 1024 + 5;  // ring deep enough for a 5x5 window
  localparam int DIM_MAX    = 1024;
  localparam int SIDE_MAX   = 5;
  localparam int RAND_ITEMS = 150;
  localparam int TALL_WORDS = 40;            // words of the cut-short tall column
  localparam int STALL_CAP  = 5000;          // idle cycles before giving up
  localparam int PIPE_WAIT  = 12;            // cycles to let the pipe empty

  // index 3 is unmapped; writes to it must change nothing
  localparam logic [wmf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  wmf_in_if  in_bus();
  wmf_out_if out_bus();
  wmf_cfg_if cfg_bus();

  window_median_filter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // --------------------------------------------------------------------------
  // Median model: own copy of registers, frame position and pixel history
  // --------------------------------------------------------------------------
  int unsigned frm_w, frm_h, win_side;
  int unsigned pos_col, pos_row;
  logic [wmf_pkg::PIX_W-1:0] pix_hist [HIST_LEN];

  // expected results, oldest first
  logic [wmf_pkg::PIX_W-1:0] median_q [$];
  logic                      last_q   [$];

  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  calm = 1'b0;   // phase with no gaps and no stalls

  function automatic int unsigned clamp_dim(logic [wmf_pkg::CFG_DATA_W-1:0] raw,
                                            int unsigned bound, int unsigned mask);
    int unsigned v;
    v = raw & mask;
    if (v == 0) return 1;
    if (v > bound) return bound;
    return v;
  endfunction

  function automatic void model_write(logic [wmf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [wmf_pkg::CFG_DATA_W-1:0] raw);
    case (idx)
      wmf_pkg::REG_FRAME_WIDTH:  frm_w    = clamp_dim(raw, DIM_MAX, 32'h7FF);
      wmf_pkg::REG_FRAME_HEIGHT: frm_h    = clamp_dim(raw, DIM_MAX, 32'h7FF);
      wmf_pkg::REG_WINDOW_SIZE:  win_side = clamp_dim(raw, SIDE_MAX, 32'h7);
      default: return;
    endcase
    pos_col = 0;
    pos_row = 0;
  endfunction

  // one accepted word; returns 1 when it yields a filtered pixel
  function automatic bit median_step(logic [wmf_pkg::PIX_W-1:0] pix,
                                     output logic [wmf_pkg::PIX_W-1:0] med,
                                     output logic last);
    int unsigned half, reach, total, lag, n, k, r, c, cnt;
    int rr, cc;
    logic [wmf_pkg::PIX_W-1:0] win [SIDE_MAX*SIDE_MAX];
    logic [wmf_pkg::PIX_W-1:0] t;
    int j;
    half  = win_side / 2;
    reach = win_side - 1 - half;
    total = frm_w * frm_h;
    lag   = reach * frm_w + reach;
    n     = pos_row * frm_w + pos_col;
    med   = '0;
    last  = 1'b0;
    if (n < total) pix_hist[n % HIST_LEN] = pix;
    pos_col++;
    if (pos_col >= frm_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (n < lag) return 1'b0;
    k = n - lag;
    if (k >= total) begin
      pos_col = 0;
      pos_row = 0;
      return 1'b0;
    end
    r = k / frm_w;
    c = k % frm_w;
    cnt = 0;
    for (int dy = -int'(half); dy <= int'(reach); dy++) begin
      rr = int'(r) + dy;
      if (rr < 0 || rr >= int'(frm_h)) continue;
      for (int dx = -int'(half); dx <= int'(reach); dx++) begin
        cc = int'(c) + dx;
        if (cc < 0 || cc >= int'(frm_w)) continue;
        win[cnt] = pix_hist[(rr * frm_w + cc) % HIST_LEN];
        cnt++;
      end
    end
    // insertion sort, then take the upper median
    for (int i = 1; i < cnt; i++) begin
      t = win[i];
      j = i;
      while (j > 0 && win[j-1] > t) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = t;
    end
    med  = win[cnt/2];
    last = (k == total - 1);
    if (last) begin
      pos_col = 0;
      pos_row = 0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (change on falling edge)
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic put_word(bit op, logic [wmf_pkg::PIX_W-1:0] pix, bit typed = 1'b0,
                          logic [wmf_pkg::PIX_W-1:0] typed_med = '0,
                          bit typed_last = 1'b0);
    int unsigned gap;
    logic [wmf_pkg::PIX_W-1:0] med;
    logic last;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= op;
    in_bus.pixel_value <= pix;
    do @(posedge clk); while (!in_bus.ready);
    if (median_step(pix, med, last)) begin
      // typed rows carry a hand-derived answer instead of the model's
      median_q.insert(median_q.size(), typed ? typed_med : med);
      last_q.insert(last_q.size(), typed ? typed_last : last);
    end
    @(negedge clk);
  endtask

  // wait for every result, then let words that yield nothing leave the pipe
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (PIPE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [wmf_pkg::CFG_IDX_W-1:0] idx,
                           logic [wmf_pkg::CFG_DATA_W-1:0] raw);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= raw;
    do @(posedge clk); while (!cfg_bus.ready);
    model_write(idx, raw);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // raw register value with junk above the decoded bits
  function automatic logic [wmf_pkg::CFG_DATA_W-1:0] junk_hi(int unsigned v,
                                                             int unsigned bits);
    return ($urandom() & ~((32'd1 << bits) - 1)) | v;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure, check at rising edge
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       stall_left = $urandom_range(10, 40);
        1, 2, 3: stall_left = $urandom_range(1, 3);
        default: stall_left = 0;
      endcase
      out_bus.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    logic [wmf_pkg::PIX_W-1:0] want_med;
    logic                      want_last;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (median_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %h last %b", out_bus.filtered_value,
                   out_bus.last_of_frame);
      end else begin
        want_med  = median_q.pop_front();
        want_last = last_q.pop_front();
        if (out_bus.filtered_value !== want_med || out_bus.last_of_frame !== want_last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, last exp %b got %b", want_med,
                     out_bus.filtered_value, want_last, out_bus.last_of_frame);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no word moving on any channel
  // --------------------------------------------------------------------------
  int unsigned quiet = 0;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= STALL_CAP) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit                             is_cfg;
    logic [wmf_pkg::CFG_IDX_W-1:0]  idx;
    logic [wmf_pkg::CFG_DATA_W-1:0] data;   // register value, or pixel
    bit                             op;
    bit                             typed;  // expected result written in below
    logic [wmf_pkg::PIX_W-1:0]      med;
    bit                             last;
  } row_t;

  localparam int N_ROWS = 31;
  row_t rows [N_ROWS] = '{
    // zero in every register clamps to 1: each pixel is its own 1x1 frame
    '{1, wmf_pkg::REG_FRAME_WIDTH,  32'h0,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_FRAME_HEIGHT, 32'h0,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_WINDOW_SIZE,  32'h0,        0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0000, 0, 1, 32'h0000_0000, 1},
    '{0, REG_UNUSED,       32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1},  // op ignored
    '{0, REG_UNUSED,       32'h8000_0001, 0, 1, 32'h8000_0001, 1},
    '{0, REG_UNUSED,       32'h7FFF_FFFE, 1, 1, 32'h7FFF_FFFE, 1},
    // 1x1 frame, side 3: lag 2, the drains carry junk that must be dropped
    '{1, wmf_pkg::REG_WINDOW_SIZE,  32'h3,        0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'hA5A5_A5A5, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0000, 1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'hFFFF_FFFF, 1, 1, 32'hA5A5_A5A5, 1},
    // 2x2 frame, side 7 clamps to 5: whole frame in every window, lag 6
    '{1, wmf_pkg::REG_FRAME_WIDTH,  32'h2,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_FRAME_HEIGHT, 32'h2,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_WINDOW_SIZE,  32'h7,        0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0009, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'hFFFF_FFFF, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0001, 1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h8000_0000, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0,        1, 0, 32'h0,        0},
    // even side: upper median of two, no lag
    '{1, wmf_pkg::REG_WINDOW_SIZE,  32'h2,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_FRAME_WIDTH,  32'h3,        0, 0, 32'h0,        0},
    '{1, wmf_pkg::REG_FRAME_HEIGHT, 32'h1,        0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0005, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0003, 0, 0, 32'h0,        0},
    '{0, REG_UNUSED,       32'h0000_0003, 0, 0, 32'h0,        0},
    // unmapped index: no effect
    '{1, REG_UNUSED,       32'hFFFF_FFFF, 0, 0, 32'h0,        0}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_frames(int unsigned frames, bit cut_short, bit tiny_pix);
    int unsigned words, lag, reach;
    logic [wmf_pkg::PIX_W-1:0] pix;
    for (int f = 0; f < frames; f++) begin
      reach = win_side - 1 - win_side / 2;
      lag   = reach * frm_w + reach;
      words = frm_w * frm_h + lag;
      if (cut_short && f == frames - 1 && words > 1) words = $urandom_range(1, words - 1);
      for (int i = 0; i < words; i++) begin
        pix = tiny_pix ? {$urandom_range(0, 1) ? 1'b1 : 1'b0, 28'h0, 3'($urandom_range(0, 7))}
                       : $urandom();
        put_word(1'($urandom_range(0, 1)), pix);
      end
    end
  endtask

  int unsigned rand_count;

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.operation   = 1'b0;
    in_bus.pixel_value = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    out_bus.ready      = 1'b1;

    // model starts from the register reset values
    frm_w    = 1024;
    frm_h    = 1024;
    win_side = 3;
    pos_col  = 0;
    pos_row  = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; register rows wait for the pipe to drain first
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        put_word(rows[i].op, rows[i].data, rows[i].typed, rows[i].med, rows[i].last);
      end
    end

    // widest row (2047 clamps to 1024), side 2 so no drains are needed
    settle();
    write_reg(wmf_pkg::REG_FRAME_WIDTH,  junk_hi(11'h7FF, wmf_pkg::DIM_W));
    write_reg(wmf_pkg::REG_FRAME_HEIGHT, junk_hi(1, wmf_pkg::DIM_W));
    write_reg(wmf_pkg::REG_WINDOW_SIZE,  junk_hi(2, wmf_pkg::WSZ_W));
    send_frames(1, 1'b0, 1'b0);
    settle();
    // tallest column, cut short; the next register write restarts it
    calm = 1'b1;
    write_reg(wmf_pkg::REG_FRAME_WIDTH,  junk_hi(1, wmf_pkg::DIM_W));
    write_reg(wmf_pkg::REG_FRAME_HEIGHT, junk_hi(11'h7FF, wmf_pkg::DIM_W));
    write_reg(wmf_pkg::REG_WINDOW_SIZE,  junk_hi(5, wmf_pkg::WSZ_W));
    repeat (TALL_WORDS) put_word(1'b0, $urandom());
    settle();
    calm = 1'b0;

    // random frames, mostly complete, a few cut short before a rewrite
    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      int unsigned w_raw, h_raw, s_raw, frames, pix_count;
      bit cut, tiny;
      settle();
      calm  = ($urandom_range(0, 7) == 0);
      w_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
      h_raw = $urandom_range(0, 8);
      s_raw = $urandom_range(0, 7);
      write_reg(wmf_pkg::REG_WINDOW_SIZE,  junk_hi(s_raw, wmf_pkg::WSZ_W));
      write_reg(wmf_pkg::REG_FRAME_HEIGHT, junk_hi(h_raw, wmf_pkg::DIM_W));
      write_reg(wmf_pkg::REG_FRAME_WIDTH,  junk_hi(w_raw, wmf_pkg::DIM_W));
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom());
      frames    = $urandom_range(1, 3);
      cut       = ($urandom_range(0, 6) == 0);
      tiny      = ($urandom_range(0, 2) == 0);
      pix_count = frm_w * frm_h;
      send_frames(frames, cut, tiny);
      rand_count += pix_count * frames;
    end

    settle();
    calm = 1'b0;
    if (median_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
